[hdl/tak_pkg.sv]
// ----------------------------------------------------------------------------
// tak_pkg
// shared types, constants and fixed-point helpers of the tilt kalman filter
// ----------------------------------------------------------------------------
package tak_pkg;

  localparam int WORD_W  = 32;
  localparam int MOP_W   = 33;  // multiplier operand, signed
  localparam int PROD_W  = 66;  // full product, signed
  localparam int RND_W   = 38;  // product after q28 rounding
  localparam int SUM_W   = 40;  // headroom for add before saturation
  localparam int DEN_W   = 34;  // innovation variance, signed
  localparam int FRAC    = 28;

  localparam int CFG_IDX_W = 8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [MOP_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DEN_W-1:0]  den_t;

  localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_GYRO    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R_MEAS    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 8'd3;

  localparam logic [WORD_W-1:0] Q_ANGLE_RST   = 32'd268435;
  localparam logic [WORD_W-1:0] Q_GYRO_RST    = 32'd805306;
  localparam logic [WORD_W-1:0] R_MEAS_RST    = 32'd134217728;
  localparam logic [WORD_W-1:0] STEP_TIME_RST = 32'd2684355;
  localparam word_t             ONE_Q428      = 32'sd268435456;

  function automatic word_t sat32(input sum_t v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[WORD_W-1:0];
  endfunction

  // q28 product back to its format, half rounded towards +inf
  function automatic rnd_t rnd_q28(input prod_t p);
    prod_t t;
    t = p + 66'sd134217728;
    return t[PROD_W-1:FRAC];
  endfunction

endpackage

[hdl/tak_mul.sv]
// ----------------------------------------------------------------------------
// tak_mul
// bit-serial signed multiplier, one multiplier bit per cycle, q28 rounding
// ----------------------------------------------------------------------------
module tak_mul
  import tak_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  mop_t op_a,
  input  mop_t op_b,
  output logic done,
  output rnd_t res
);

  localparam int STEPS = MOP_W;

  logic [MOP_W-1:0]    mag_a_r;
  logic [2*MOP_W:0]    p_r;      // partial sum above, multiplier below
  logic                neg_r;
  logic                busy_r;
  logic [5:0]          cnt_r;
  prod_t               prod_r;
  rnd_t                res_r;
  logic                done_r;
  logic [MOP_W+1:0]    part;

  assign part = {1'b0, p_r[2*MOP_W:MOP_W]} + (p_r[0] ? {2'b00, mag_a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulses on the cycle after the rounding step
      done_r <= !start && busy_r && (cnt_r > 6'(STEPS));
      if (start) begin
        mag_a_r <= op_a[MOP_W-1] ? MOP_W'(-op_a) : MOP_W'(op_a);
        p_r     <= {{(MOP_W+1){1'b0}}, (op_b[MOP_W-1] ? MOP_W'(-op_b) : MOP_W'(op_b))};
        neg_r   <= op_a[MOP_W-1] ^ op_b[MOP_W-1];
        cnt_r   <= '0;
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r < 6'(STEPS)) begin
          p_r <= {part, p_r[MOP_W-1:1]};
        end else if (cnt_r == 6'(STEPS)) begin
          prod_r <= neg_r ? -$signed(p_r[PROD_W-1:0]) : $signed(p_r[PROD_W-1:0]);
        end else begin
          res_r  <= rnd_q28(prod_r);
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

[hdl/tak_div.sv]
// ----------------------------------------------------------------------------
// tak_div
// restoring divider for the q28 gain, one quotient bit per cycle, saturated
// ----------------------------------------------------------------------------
module tak_div
  import tak_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t num,
  input  den_t  den,
  output logic  done,
  output word_t gain
);

  localparam int QW = WORD_W + FRAC;

  logic [QW-1:0]      quo_r;
  logic [DEN_W-2:0]   rem_r;
  logic [DEN_W-2:0]   den_r;
  logic               neg_r;
  logic               busy_r;
  logic               fin_r;
  logic [5:0]         cnt_r;
  logic               done_r;
  word_t              gain_r;
  logic [DEN_W-1:0]   trial;
  logic               fit;
  logic [WORD_W-1:0]  mag;

  assign mag   = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
  assign trial = {rem_r, quo_r[QW-1]};
  assign fit   = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // zero gain at once, otherwise after the last quotient bit
      done_r <= (start && (den <= 0)) || (!start && !busy_r && fin_r);
      if (start) begin
        if (den <= 0) begin
          gain_r <= '0;
        end else begin
          quo_r  <= {mag, {FRAC{1'b0}}};
          rem_r  <= '0;
          den_r  <= den[DEN_W-2:0];
          neg_r  <= num[WORD_W-1];
          cnt_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r  <= fit ? (DEN_W-1)'(trial - {1'b0, den_r}) : trial[DEN_W-2:0];
        quo_r  <= {quo_r[QW-2:0], fit};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'(QW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        if (neg_r) begin
          gain_r <= (quo_r > 60'd2147483648) ? 32'sh80000000 : -$signed(quo_r[WORD_W-1:0]);
        end else begin
          gain_r <= (quo_r > 60'd2147483647) ? 32'sh7fffffff : $signed(quo_r[WORD_W-1:0]);
        end
      end
    end
  end

  assign done = done_r;
  assign gain = gain_r;

endmodule

[hdl/tilt_angle_kalman_filter.sv]
// each input transaction runs ten serial multiplies and two divides before
// its result is valid; a divide with non-positive variance ends at once
// one transaction is in flight at a time, and a result stall holds the next; the
// bit-serial multiplier and divider take one item at a time
// reset: synchronous active-low rst_n restores register defaults, zero
// estimates and unit diagonal covariance in every axis bank
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter
// two-state angle / gyro bias kalman filter with one state bank per axis
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter
  import tak_pkg::*;
#(
  parameter int AXES = 2
)(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_axis,
  input  logic signed [31:0]   in_accel_angle,
  input  logic signed [31:0]   in_gyro_rate,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_axis_out,
  output logic signed [31:0]   out_angle_out,
  output logic signed [31:0]   out_bias_out,
  // register write port
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int BW = (AXES > 1) ? $clog2(AXES) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  // filter steps, in order
  localparam logic [3:0] SP_RATE  = 4'd0;   // predicted angle
  localparam logic [3:0] SP_DAA   = 4'd1;   // covariance prediction
  localparam logic [3:0] SP_DAB   = 4'd2;
  localparam logic [3:0] SP_DBB   = 4'd3;
  localparam logic [3:0] SP_K0    = 4'd4;   // gains
  localparam logic [3:0] SP_K1    = 4'd5;
  localparam logic [3:0] SP_UAA   = 4'd6;   // covariance correction
  localparam logic [3:0] SP_UAB   = 4'd7;
  localparam logic [3:0] SP_UBA   = 4'd8;
  localparam logic [3:0] SP_UBB   = 4'd9;
  localparam logic [3:0] SP_UANG  = 4'd10;  // estimate correction
  localparam logic [3:0] SP_UBIAS = 4'd11;

  // configuration registers
  logic [31:0] q_angle_r, q_gyro_r, r_meas_r, step_time_r;

  // per-axis state banks
  word_t ang_bank_r  [AXES];
  word_t bias_bank_r [AXES];
  word_t aa_bank_r   [AXES];
  word_t ab_bank_r   [AXES];
  word_t ba_bank_r   [AXES];
  word_t bb_bank_r   [AXES];

  // working registers of the step in flight
  logic [1:0]    state_r;
  logic [3:0]    step_r;
  logic [BW-1:0] bank_r;
  logic          axis_r;
  word_t         accel_r, ang_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  word_t         rate_r, d0_r, err_r, k0_r, k1_r, res_ang_r, res_bias_r;

  // result register
  logic          out_valid_r;
  logic          out_axis_r;
  word_t         out_angle_r, out_bias_r;

  logic [BW-1:0] in_bank;
  logic          in_acc;
  logic          is_div;
  logic          unit_done;
  logic          mul_start, div_start, mul_done, div_done;
  mop_t          mul_a, mul_b;
  rnd_t          mul_res;
  word_t         div_num, div_gain;
  den_t          e_var;
  sum_t          r_ext;

  // out-of-range axis folds onto the last bank
  always_comb begin
    if (32'(in_axis) < AXES) begin
      in_bank = BW'(in_axis);
    end else begin
      in_bank = BW'(AXES - 1);
    end
  end

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign is_div    = (step_r == SP_K0) || (step_r == SP_K1);
  assign unit_done = is_div ? div_done : mul_done;
  assign mul_start = (state_r == ST_ISSUE) && !is_div;
  assign div_start = (state_r == ST_ISSUE) && is_div;

  // innovation variance
  assign e_var   = $signed({2'b00, r_meas_r}) + DEN_W'(aa_r);
  assign div_num = (step_r == SP_K0) ? aa_r : ba_r;
  assign r_ext   = SUM_W'(mul_res);

  // multiplier operands for each step
  always_comb begin
    case (step_r)
      SP_RATE:  begin mul_a = MOP_W'(rate_r);            mul_b = $signed({1'b0, step_time_r}); end
      SP_DAA:   begin mul_a = MOP_W'(d0_r);              mul_b = $signed({1'b0, step_time_r}); end
      SP_DAB:   begin mul_a = MOP_W'(bb_r);              mul_b = $signed({1'b0, step_time_r}); end
      SP_DBB:   begin mul_a = $signed({1'b0, q_gyro_r}); mul_b = $signed({1'b0, step_time_r}); end
      SP_UAA:   begin mul_a = MOP_W'(k0_r);              mul_b = MOP_W'(aa_r);  end
      SP_UAB:   begin mul_a = MOP_W'(k0_r);              mul_b = MOP_W'(ab_r);  end
      SP_UBA:   begin mul_a = MOP_W'(k1_r);              mul_b = MOP_W'(aa_r);  end
      SP_UBB:   begin mul_a = MOP_W'(k1_r);              mul_b = MOP_W'(ab_r);  end
      SP_UANG:  begin mul_a = MOP_W'(k0_r);              mul_b = MOP_W'(err_r); end
      SP_UBIAS: begin mul_a = MOP_W'(k1_r);              mul_b = MOP_W'(err_r); end
      default:  begin mul_a = '0;                        mul_b = '0;            end
    endcase
  end

  tak_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  tak_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (e_var),
    .done  (div_done),
    .gain  (div_gain)
  );

  // register writes; indexes beyond the list fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_angle_r   <= Q_ANGLE_RST;
      q_gyro_r    <= Q_GYRO_RST;
      r_meas_r    <= R_MEAS_RST;
      step_time_r <= STEP_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_Q_ANGLE:   q_angle_r   <= cfg_data;
        REG_Q_GYRO:    q_gyro_r    <= cfg_data;
        REG_R_MEAS:    r_meas_r    <= cfg_data;
        REG_STEP_TIME: step_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_RATE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        ang_bank_r[i]  <= '0;
        bias_bank_r[i] <= '0;
        aa_bank_r[i]   <= ONE_Q428;
        ab_bank_r[i]   <= '0;
        ba_bank_r[i]   <= '0;
        bb_bank_r[i]   <= ONE_Q428;
      end
    end else begin
      // result taken; a new one being loaded is handled in ST_OUT
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // pick up the bank and form the rate and covariance drift terms
            bank_r  <= in_bank;
            axis_r  <= in_axis;
            accel_r <= in_accel_angle;
            ang_r   <= ang_bank_r[in_bank];
            bias_r  <= bias_bank_r[in_bank];
            aa_r    <= aa_bank_r[in_bank];
            ab_r    <= ab_bank_r[in_bank];
            ba_r    <= ba_bank_r[in_bank];
            bb_r    <= bb_bank_r[in_bank];
            rate_r  <= sat32(SUM_W'(in_gyro_rate) - SUM_W'(bias_bank_r[in_bank]));
            d0_r    <= sat32($signed({8'd0, q_angle_r}) - SUM_W'(ab_bank_r[in_bank])
                             - SUM_W'(ba_bank_r[in_bank]));
            step_r  <= SP_RATE;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (unit_done) begin
            case (step_r)
              SP_RATE: ang_r <= sat32(SUM_W'(ang_r) + r_ext);
              SP_DAA: begin
                aa_r  <= sat32(SUM_W'(aa_r) + r_ext);
                // measurement residual against the predicted angle
                err_r <= sat32(SUM_W'(accel_r) - SUM_W'(ang_r));
              end
              SP_DAB: begin
                ab_r <= sat32(SUM_W'(ab_r) - r_ext);
                ba_r <= sat32(SUM_W'(ba_r) - r_ext);
              end
              SP_DBB:   bb_r <= sat32(SUM_W'(bb_r) + r_ext);
              SP_K0:    k0_r <= div_gain;
              SP_K1:    k1_r <= div_gain;
              // corrections go straight to the bank, predicted values stay
              SP_UAA:   aa_bank_r[bank_r] <= sat32(SUM_W'(aa_r) - r_ext);
              SP_UAB:   ab_bank_r[bank_r] <= sat32(SUM_W'(ab_r) - r_ext);
              SP_UBA:   ba_bank_r[bank_r] <= sat32(SUM_W'(ba_r) - r_ext);
              SP_UBB:   bb_bank_r[bank_r] <= sat32(SUM_W'(bb_r) - r_ext);
              SP_UANG: begin
                ang_bank_r[bank_r] <= sat32(SUM_W'(ang_r) + r_ext);
                res_ang_r          <= sat32(SUM_W'(ang_r) + r_ext);
              end
              SP_UBIAS: begin
                bias_bank_r[bank_r] <= sat32(SUM_W'(bias_r) + r_ext);
                res_bias_r          <= sat32(SUM_W'(bias_r) + r_ext);
              end
              default: ;
            endcase
            if (step_r == SP_UBIAS) begin
              state_r <= ST_OUT;
            end else begin
              step_r  <= step_r + 4'd1;
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_OUT: begin
          // hand over once the result slot is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_axis_r  <= axis_r;
            out_angle_r <= res_ang_r;
            out_bias_r  <= res_bias_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_axis_out  = out_axis_r;
  assign out_angle_out = out_angle_r;
  assign out_bias_out  = out_bias_r;

endmodule
